// ===== hdl/pcu_pkg.sv =====
package pcu_pkg;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_HEX   = 2'd2;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CTRL_MAX   = 8'd31;
    localparam logic [7:0] CHAR_DEL   = 8'd127;

    localparam int BURST_MAX = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] err;
    } pcu_result_t;

    typedef struct packed {
        logic [1:0]                       count;
        pcu_result_t [BURST_MAX-1:0]      res;
    } pcu_burst_t;

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h61 + 8'd10)};
        end
        return v;
    endfunction

endpackage

// ===== hdl/pcu_decode.sv =====
module pcu_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output pcu_pkg::pcu_burst_t burst
);
    import pcu_pkg::*;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_PCT,
        MODE_FIRST,
        MODE_DROP
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [7:0] first_reg, first_next;
    logic [4:0] hi_val, lo_val;
    logic [7:0] decoded;

    assign hi_val  = hex_value(first_reg);
    assign lo_val  = hex_value(in_byte);
    assign decoded = {hi_val[3:0], lo_val[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        first_next = first_reg;
        burst      = '0;
        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (in_byte != CHAR_PCT)
                begin
                    burst.count  = 2'd1;
                    burst.res[0] = '{data: in_byte, last: in_last, err: ERR_NONE};
                end
                else if (in_last)
                begin
                    burst.count  = 2'd1;
                    burst.res[0] = '{data: 8'd0, last: 1'b1, err: ERR_TRUNC};
                end
                else
                begin
                    mode_next = MODE_PCT;
                end
            end
            MODE_PCT:
            begin
                if (in_last)
                begin
                    mode_next    = MODE_NORMAL;
                    burst.count  = 2'd1;
                    burst.res[0] = '{data: 8'd0, last: 1'b1, err: ERR_TRUNC};
                end
                else
                begin
                    first_next = in_byte;
                    mode_next  = MODE_FIRST;
                end
            end
            MODE_FIRST:
            begin
                if (hi_val[4] || lo_val[4])
                begin
                    mode_next    = in_last ? MODE_NORMAL : MODE_DROP;
                    burst.count  = 2'd1;
                    burst.res[0] = '{data: 8'd0, last: 1'b1, err: ERR_HEX};
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    if (decoded > CTRL_MAX && decoded != CHAR_DEL && decoded != CHAR_COLON)
                    begin
                        burst.count  = 2'd1;
                        burst.res[0] = '{data: decoded, last: in_last, err: ERR_NONE};
                    end
                    else
                    begin
                        // Unsafe decoded value: send the escape on unchanged.
                        burst.count  = 2'd3;
                        burst.res[0] = '{data: CHAR_PCT, last: 1'b0, err: ERR_NONE};
                        burst.res[1] = '{data: first_reg, last: 1'b0, err: ERR_NONE};
                        burst.res[2] = '{data: in_byte, last: in_last, err: ERR_NONE};
                    end
                end
            end
            MODE_DROP:
            begin
                if (in_last)
                begin
                    mode_next = MODE_NORMAL;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            first_reg <= '0;
        end
        else if (take)
        begin
            mode_reg  <= mode_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== hdl/pcu_emit.sv =====
module pcu_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  pcu_pkg::pcu_burst_t  burst,
    output logic                 can_load,
    output logic                 valid,
    input  logic                 ready,
    output pcu_pkg::pcu_result_t head
);
    import pcu_pkg::*;

    logic [1:0]                  cnt_reg, cnt_next;
    pcu_result_t [BURST_MAX-1:0] slot_reg, slot_next;
    logic                        pop;

    assign valid    = (cnt_reg != 2'd0);
    assign pop      = valid && ready;
    assign head     = slot_reg[0];
    // A new burst may enter once at most the final result is left and it leaves now.
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && ready);

    always_comb
    begin
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        if (load)
        begin
            cnt_next  = burst.count;
            slot_next = burst.res;
        end
        else if (pop)
        begin
            cnt_next     = cnt_reg - 2'd1;
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

// ===== hdl/percent_unescape_stream.sv =====
// Percent-escape decoder for a byte stream.
// The slave channel takes one raw string byte per item, with tlast on the
// final byte of the string. The master channel gives result items: the
// decoded or passed-through byte, tlast on the last result of a string, and
// an error code in tuser (0 ok, 1 truncated escape, 2 non-hex digit).
// A '%' and its first digit give no result; the second digit gives one
// decoded byte, or three items ('%' and both raw digits) when the decoded
// value is a control code, DEL or a colon. An error result closes the string
// and the rest of its bytes are dropped.
// A result appears on the master side in the cycle after its input item is
// accepted. One item is accepted per cycle while the receiver keeps up; a
// three-item re-emit holds s_tready low until only its last item is left and
// is being taken, as the single result buffer serializes the burst.
// While the receiver stalls, the buffered result holds and s_tready drops
// once the buffer cannot take the next item's results.
// Reset clears the decode state to passthrough and empties the result
// buffer; no clearing pass is needed.
module percent_unescape_stream (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,   // out_last
    output logic [1:0] m_tuser    // [1:0] error_code
);
    import pcu_pkg::*;

    logic        take;
    pcu_burst_t  burst;
    pcu_result_t head;
    logic        can_load;

    // An item is taken only when its results can all go into the buffer.
    assign s_tready = can_load;
    assign take     = s_tvalid && s_tready;

    pcu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .burst   (burst)
    );

    pcu_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .burst    (burst),
        .can_load (can_load),
        .valid    (m_tvalid),
        .ready    (m_tready),
        .head     (head)
    );

    assign m_tdata = head.data;
    assign m_tlast = head.last;
    assign m_tuser = head.err;

endmodule
